/* hdl/drsu_pkg.sv */
package drsu_pkg;

   // Geometry
   localparam int QUERY_HEADS = 16;
   localparam int HEAD_DIM    = 64;
   localparam int KV_SLOTS    = 64;
   localparam int ELEM_W      = 6;
   localparam int HEAD_W      = 6;
   localparam int QH_W        = (QUERY_HEADS > 1) ? $clog2(QUERY_HEADS) : 1;
   localparam int DATA_W      = 32;
   localparam int CFG_W       = 7;
   localparam int ACC_W       = DATA_W + 7;

   // Register indexes (byte address bit 2)
   localparam logic REG_GROUP_SIZE = 1'b0;
   localparam logic REG_KV_HEADS   = 1'b1;

   // Constant one in Q16.16
   localparam logic [16:0] FX_ONE = 17'd65536;

   // Sigmoid samples at 0..8, Q16.16
   localparam logic [15:0] SIG_TAB [9] = '{
      16'd32768, 16'd47911, 16'd57724, 16'd62428, 16'd64357,
      16'd65097, 16'd65374, 16'd65476, 16'd65514
   };

   localparam logic signed [63:0] SAT_HI = 64'sh0000_0000_7FFF_FFFF;
   localparam logic signed [63:0] SAT_LO = -64'sh0000_0000_8000_0000;

   // Clamp a wide signed value to 32 bits
   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v > SAT_HI) begin
         r = 32'sh7FFF_FFFF;
      end else if (v < SAT_LO) begin
         r = 32'sh8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   // Piecewise linear sigmoid on Q16.16, saturated beyond 8.0
   function automatic logic signed [31:0] fx_sigmoid(input logic signed [31:0] x);
      logic [31:0] a;
      logic [3:0]  idx;
      logic [15:0] lo;
      logic [15:0] hi;
      logic [31:0] stepv;
      logic [16:0] f;
      logic [16:0] r;
      a = x[31] ? (~x + 32'd1) : x;
      if (a >= 32'h0008_0000) begin
         f = {1'b0, SIG_TAB[8]};
      end else begin
         idx   = {1'b0, a[18:16]};
         lo    = SIG_TAB[idx];
         hi    = SIG_TAB[idx + 4'd1];
         stepv = (hi - lo) * a[15:0];
         f     = {1'b0, lo} + {1'b0, stepv[31:16]};
      end
      r = x[31] ? (FX_ONE - f) : f;
      return {15'd0, r};
   endfunction

endpackage

/* hdl/delta_rule_state_update.sv */
// Timing: a trigger (query element with last set) runs to the final context transaction,
// waiting on result stalls, since every state entry passes the single multiplier in
// three passes; other items are written straight to memory. Throughput: one head
// update at a time, input held off until it ends.
// Reset: synchronous; a per-head valid bit cleared by reset stands in for a clearing
// pass, so the block accepts items right after reset.
module delta_rule_state_update import drsu_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [79:0] req_tdata,   // head, elem_index, value_a, value_b
   input  logic [0:0]  req_tuser,   // op
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // ctx_value, ctx_index
   output logic        rsp_tlast,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_DIV, ST_BETA_RD, ST_BETA, ST_JSTART, ST_JDIFF, ST_RD, ST_OPA,
      ST_MW, ST_MR, ST_MW2, ST_MR2, ST_JEND, ST_EMIT
   } state_type;

   typedef enum logic [1:0] {PASS_ATTN, PASS_UPD, PASS_CTX} pass_type;

   localparam int S_AW = QH_W + 2 * ELEM_W;
   localparam int K_AW = HEAD_W + ELEM_W;
   localparam logic [ELEM_W-1:0] LAST_IDX = ELEM_W'(HEAD_DIM - 1);

   state_type                state_ff;
   pass_type                 pass_ff;
   logic [QH_W-1:0]          h_ff;
   logic [CFG_W-1:0]         rem_ff;
   logic [CFG_W-1:0]         quo_ff;
   logic [CFG_W-1:0]         g_ff;
   logic [HEAD_W-1:0]        kh_ff;
   logic signed [31:0]       beta_ff;
   logic signed [31:0]       d_ff;
   logic signed [31:0]       s_ff;
   logic signed [ACC_W-1:0]  acc_ff;
   logic [ELEM_W-1:0]        i_ff;
   logic [ELEM_W-1:0]        j_ff;
   logic [QUERY_HEADS-1:0]   hv_ff;
   logic                     rsp_valid_ff;
   logic [31:0]              rsp_value_ff;
   logic [ELEM_W-1:0]        rsp_index_ff;
   logic                     rsp_last_ff;
   logic [CFG_W-1:0]         grp_ff;
   logic [CFG_W-1:0]         kvh_ff;

   logic [HEAD_W-1:0] in_head;
   logic [ELEM_W-1:0] in_el;
   logic [31:0]       in_va;
   logic [31:0]       in_vb;
   logic              in_op;
   logic              req_fire;
   logic              el_ok;
   logic              qh_ok;
   logic              kv_we;
   logic              q_we;
   logic              trig;
   logic              busy;
   logic [CFG_W-1:0]  kvm1;

   logic [K_AW-1:0]   key_addr;
   logic [K_AW-1:0]   val_addr;
   logic [ELEM_W-1:0] q_addr;
   logic [S_AW-1:0]   st_addr;
   logic              key_re;
   logic              val_re;
   logic              q_re;
   logic              attn_re;
   logic              attn_we;
   logic              st_re;
   logic              st_we;
   logic [31:0]       key_rdata;
   logic [31:0]       val_rdata;
   logic [31:0]       q_rdata;
   logic [31:0]       attn_rdata;
   logic [31:0]       st_rdata;
   logic signed [31:0] attn_wdata;
   logic signed [31:0] st_wdata;
   logic signed [31:0] s_eff;
   logic signed [31:0] acc_sat;
   logic signed [31:0] mul_a;
   logic signed [31:0] mul_b;
   logic signed [31:0] mul_y;

   // Unpack the input transaction
   assign in_head  = req_tdata[5:0];
   assign in_el    = req_tdata[11:6];
   assign in_va    = req_tdata[43:12];
   assign in_vb    = req_tdata[75:44];
   assign in_op    = req_tuser[0];
   assign busy     = (state_ff != ST_IDLE);
   assign req_tready = ~busy & ~reset;
   assign req_fire = req_tvalid & req_tready;
   assign el_ok    = ({1'b0, in_el} < 7'(HEAD_DIM));
   assign qh_ok    = ({1'b0, in_head} < 7'(QUERY_HEADS));
   assign kv_we    = req_fire & ~in_op & el_ok;
   assign q_we     = req_fire & in_op & qh_ok & el_ok;
   assign trig     = req_fire & in_op & qh_ok & req_tlast;
   assign kvm1     = ((kvh_ff == '0) ? 7'd1 : kvh_ff) - 7'd1;

   // Configuration registers
   assign csr_pready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         grp_ff <= 7'd1;
         kvh_ff <= 7'd1;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         unique case (csr_paddr[2])
            REG_GROUP_SIZE: grp_ff <= csr_pwdata[CFG_W-1:0];
            REG_KV_HEADS:   kvh_ff <= csr_pwdata[CFG_W-1:0];
            default:        grp_ff <= grp_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         REG_GROUP_SIZE: csr_prdata = {25'd0, grp_ff};
         REG_KV_HEADS:   csr_prdata = {25'd0, kvh_ff};
         default:        csr_prdata = '0;
      endcase
   end

   // Memory addressing
   assign key_addr = busy ? {kh_ff, (state_ff == ST_BETA_RD) ? '0 : i_ff} : {in_head, in_el};
   assign val_addr = busy ? {kh_ff, j_ff} : {in_head, in_el};
   assign q_addr   = busy ? i_ff : in_el;
   assign st_addr  = {h_ff, i_ff, j_ff};
   assign key_re   = (state_ff == ST_BETA_RD) || (state_ff == ST_RD);
   assign val_re   = (state_ff == ST_JSTART);
   assign attn_re  = (state_ff == ST_JSTART);
   assign q_re     = (state_ff == ST_RD);
   assign st_re    = (state_ff == ST_RD);
   assign st_we    = (state_ff == ST_MR2);
   assign attn_we  = (state_ff == ST_JEND) && (pass_ff == PASS_ATTN);

   // An untouched head matrix reads as zero
   assign s_eff    = hv_ff[h_ff] ? st_rdata : 32'sd0;
   assign acc_sat  = sat32($signed({{(64-ACC_W){acc_ff[ACC_W-1]}}, acc_ff}));
   assign attn_wdata = acc_sat;
   assign st_wdata = sat32($signed({{32{s_ff[31]}}, s_ff} + {{32{mul_y[31]}}, mul_y}));

   // Select multiplier operands
   always_comb begin
      if (state_ff == ST_MR) begin
         mul_a = beta_ff;
         mul_b = mul_y;
      end else begin
         unique case (pass_ff)
            PASS_ATTN: begin
               mul_a = s_eff;
               mul_b = key_rdata;
            end
            PASS_UPD: begin
               mul_a = key_rdata;
               mul_b = d_ff;
            end
            default: begin
               mul_a = q_rdata;
               mul_b = s_eff;
            end
         endcase
      end
   end

   drsu_ram #(.DEPTH(KV_SLOTS * 64), .WIDTH(DATA_W)) u_key (
      .clock(clock), .we(kv_we), .re(key_re), .addr(key_addr),
      .wdata(in_va), .rdata(key_rdata));

   drsu_ram #(.DEPTH(KV_SLOTS * 64), .WIDTH(DATA_W)) u_val (
      .clock(clock), .we(kv_we), .re(val_re), .addr(val_addr),
      .wdata(in_vb), .rdata(val_rdata));

   drsu_ram #(.DEPTH(64), .WIDTH(DATA_W)) u_query (
      .clock(clock), .we(q_we), .re(q_re), .addr(q_addr),
      .wdata(in_va), .rdata(q_rdata));

   drsu_ram #(.DEPTH(64), .WIDTH(DATA_W)) u_attn (
      .clock(clock), .we(attn_we), .re(attn_re), .addr(j_ff),
      .wdata(attn_wdata), .rdata(attn_rdata));

   drsu_ram #(.DEPTH(2 ** S_AW), .WIDTH(DATA_W)) u_state (
      .clock(clock), .we(st_we), .re(st_re), .addr(st_addr),
      .wdata(st_wdata), .rdata(st_rdata));

   drsu_fxmul u_mul (.clock(clock), .a(mul_a), .b(mul_b), .y(mul_y));

   // Sequencer: head mapping, beta, then attention, update and context passes
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pass_ff      <= PASS_ATTN;
         hv_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (trig) begin
                  h_ff     <= in_head[QH_W-1:0];
                  rem_ff   <= {1'b0, in_head};
                  quo_ff   <= '0;
                  g_ff     <= (grp_ff == '0) ? 7'd1 : grp_ff;
                  state_ff <= ST_DIV;
               end
            end
            ST_DIV: begin
               if (rem_ff >= g_ff) begin
                  rem_ff <= rem_ff - g_ff;
                  quo_ff <= quo_ff + 7'd1;
               end else begin
                  kh_ff    <= (quo_ff > kvm1) ? kvm1[HEAD_W-1:0] : quo_ff[HEAD_W-1:0];
                  state_ff <= ST_BETA_RD;
               end
            end
            ST_BETA_RD: state_ff <= ST_BETA;
            ST_BETA: begin
               beta_ff  <= fx_sigmoid(key_rdata);
               pass_ff  <= PASS_ATTN;
               i_ff     <= '0;
               j_ff     <= '0;
               acc_ff   <= '0;
               state_ff <= ST_RD;
            end
            ST_JSTART: state_ff <= ST_JDIFF;
            ST_JDIFF: begin
               d_ff <= sat32($signed({{32{val_rdata[31]}}, val_rdata}
                                     - {{32{attn_rdata[31]}}, attn_rdata}));
               i_ff     <= '0;
               state_ff <= ST_RD;
            end
            ST_RD: state_ff <= ST_OPA;
            ST_OPA: begin
               s_ff     <= s_eff;
               state_ff <= ST_MW;
            end
            ST_MW: state_ff <= ST_MR;
            ST_MR: begin
               if (pass_ff == PASS_UPD) begin
                  state_ff <= ST_MW2;
               end else begin
                  acc_ff <= acc_ff + {{(ACC_W-32){mul_y[31]}}, mul_y};
                  if (i_ff == LAST_IDX) begin
                     state_ff <= ST_JEND;
                  end else begin
                     i_ff     <= i_ff + 1'b1;
                     state_ff <= ST_RD;
                  end
               end
            end
            ST_MW2: state_ff <= ST_MR2;
            ST_MR2: begin
               if (i_ff == LAST_IDX) begin
                  state_ff <= ST_JEND;
               end else begin
                  i_ff     <= i_ff + 1'b1;
                  state_ff <= ST_RD;
               end
            end
            ST_JEND: begin
               unique case (pass_ff)
                  PASS_ATTN: begin
                     i_ff   <= '0;
                     acc_ff <= '0;
                     if (j_ff == LAST_IDX) begin
                        pass_ff  <= PASS_UPD;
                        j_ff     <= '0;
                        state_ff <= ST_JSTART;
                     end else begin
                        j_ff     <= j_ff + 1'b1;
                        state_ff <= ST_RD;
                     end
                  end
                  PASS_UPD: begin
                     if (j_ff == LAST_IDX) begin
                        hv_ff[h_ff] <= 1'b1;
                        pass_ff     <= PASS_CTX;
                        i_ff        <= '0;
                        j_ff        <= '0;
                        acc_ff      <= '0;
                        state_ff    <= ST_RD;
                     end else begin
                        j_ff     <= j_ff + 1'b1;
                        state_ff <= ST_JSTART;
                     end
                  end
                  default: begin
                     rsp_valid_ff <= 1'b1;
                     rsp_value_ff <= acc_sat;
                     rsp_index_ff <= j_ff;
                     rsp_last_ff  <= (j_ff == LAST_IDX);
                     state_ff     <= ST_EMIT;
                  end
               endcase
            end
            ST_EMIT: begin
               if (rsp_tready) begin
                  rsp_valid_ff <= 1'b0;
                  i_ff         <= '0;
                  acc_ff       <= '0;
                  if (j_ff == LAST_IDX) begin
                     state_ff <= ST_IDLE;
                  end else begin
                     j_ff     <= j_ff + 1'b1;
                     state_ff <= ST_RD;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_index_ff, rsp_value_ff};
   assign rsp_tlast  = rsp_last_ff;

   // Checks
   a_no_input_while_result: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("input taken while a context transaction is pending");

   a_state_write_busy: assert property (@(posedge clock) disable iff (reset)
      st_we |-> (busy && pass_ff == PASS_UPD))
      else $error("state write outside the update pass");

   a_last_index: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |-> (rsp_tdata[37:32] == LAST_IDX))
      else $error("last context transaction at wrong index");

   a_kh_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_BETA_RD) |-> ({1'b0, kh_ff} <= kvm1))
      else $error("key head beyond configured count");

   a_emit_leaves: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && rsp_tready) |=> !rsp_tvalid)
      else $error("context transaction repeated");

endmodule

/* hdl/drsu_ram.sv */
module drsu_ram #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Single port: write or registered read
   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

/* hdl/drsu_fxmul.sv */
module drsu_fxmul import drsu_pkg::*; (
   input  logic                     clock,
   input  logic signed [DATA_W-1:0] a,
   input  logic signed [DATA_W-1:0] b,
   output logic signed [DATA_W-1:0] y
);

   logic signed [63:0]       prod_in;
   logic signed [63:0]       prod_ff;
   logic signed [63:0]       rnd;
   logic signed [DATA_W-1:0] y_in;
   logic signed [DATA_W-1:0] y_ff;

   // Full product, then round half up and clamp
   always_comb begin
      prod_in = a * b;
      rnd     = (prod_ff + 64'sd32768) >>> 16;
      y_in    = sat32(rnd);
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      y_ff    <= y_in;
   end

   assign y = y_ff;

endmodule
